// ----- hw/rtl/lzwc_pkg.sv -----
package lzwc_pkg;

	localparam int CODE_W  = 11;
	localparam int SYM_W   = 10;
	localparam int COUNT_W = 20;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef struct packed {
		logic [CODE_W-1:0] prefix;
		logic [SYM_W-1:0]  symbol;
	} entry_t;

	typedef struct packed {
		logic              has_code;
		logic [CODE_W-1:0] code;
		logic              is_final;
		logic [SYM_W-1:0]  final_symbol;
	} result_t;

endpackage

// ----- hw/rtl/lzwc_dict.sv -----
module lzwc_dict #(
	parameter int DEPTH = 1023,
	parameter int AW    = 10
) (
	input  logic                   clk,
	input  logic                   wr_en,
	input  logic [AW-1:0]          wr_addr,
	input  lzwc_pkg::entry_t       wr_data,
	input  logic                   rd_en,
	input  logic [AW-1:0]          rd_addr,
	output lzwc_pkg::entry_t       rd_data
);
	import lzwc_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/lzwc_engine.sv -----
module lzwc_engine #(
	parameter int ALPHABET_SIZE = 1000,
	parameter int DICT_ENTRIES  = 1023
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [lzwc_pkg::SYM_W-1:0]        symbol,
	input  logic [lzwc_pkg::COUNT_W-1:0]      final_code_count,
	input  logic                              out_free,
	output logic                              res_valid,
	output lzwc_pkg::result_t                 res
);
	import lzwc_pkg::*;

	localparam int AW = $clog2(DICT_ENTRIES);
	localparam int UW = $clog2(DICT_ENTRIES + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0]         st_q;
	logic [SYM_W-1:0]   sym_q;
	logic [CODE_W-1:0]  cur_prefix_q;
	logic               prefix_valid_q;
	logic [UW-1:0]      used_q;
	logic [COUNT_W-1:0] count_q;
	logic [AW-1:0]      idx_q;
	logic               hit_q;
	logic [CODE_W-1:0]  hit_code_q;

	logic               accept;
	logic [SYM_W-1:0]   sym_sat;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	entry_t             rd_data;
	logic               wr_en;
	entry_t             wr_data;
	logic               match;
	logic               last;
	logic               commit;
	logic               table_full;
	logic [COUNT_W-1:0] count_inc;

	assign in_stall   = (st_q != ST_IDLE);
	assign accept     = in_valid && !in_stall;
	assign sym_sat    = ({1'b0, symbol} >= (SYM_W + 1)'(ALPHABET_SIZE)) ?
		SYM_W'(ALPHABET_SIZE - 1) : symbol;
	assign table_full = (used_q == UW'(DICT_ENTRIES));

	assign rd_en   = accept || (st_q == ST_SEARCH);
	assign rd_addr = (st_q == ST_IDLE) ? '0 : idx_q + AW'(1);
	assign match   = (rd_data.prefix == cur_prefix_q) && (rd_data.symbol == sym_q);
	assign last    = ((UW'(idx_q) + UW'(1)) == used_q);

	assign commit    = (st_q == ST_FINISH) && out_free;
	assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_W'(1);

	assign wr_en          = commit && !hit_q && !table_full;
	assign wr_data.prefix = cur_prefix_q;
	assign wr_data.symbol = sym_q;

	lzwc_dict #(
		.DEPTH (DICT_ENTRIES),
		.AW    (AW)
	) u_dict (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (used_q[AW-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		res = '0;
		if (hit_q) begin
			if (count_q == final_code_count) begin
				res.has_code = 1'b1;
				res.code     = hit_code_q;
				res.is_final = 1'b1;
			end
		end else begin
			res.has_code = 1'b1;
			res.code     = cur_prefix_q;
			if (count_inc == final_code_count) begin
				res.is_final     = 1'b1;
				res.final_symbol = sym_q;
			end
		end
	end

	assign res_valid = commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= ST_IDLE;
			cur_prefix_q   <= '0;
			prefix_valid_q <= 1'b0;
			used_q         <= '0;
			count_q        <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						if (prefix_valid_q && (used_q != '0)) begin
							st_q <= ST_SEARCH;
						end else begin
							st_q <= ST_FINISH;
						end
					end
				end
				ST_SEARCH: begin
					if (match || last) begin
						st_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (commit) begin
						st_q           <= ST_IDLE;
						prefix_valid_q <= 1'b1;
						if (hit_q) begin
							cur_prefix_q <= hit_code_q;
						end else begin
							cur_prefix_q <= CODE_W'(sym_q);
							count_q      <= count_inc;
							if (!table_full) begin
								used_q <= used_q + UW'(1);
							end
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sym_q      <= sym_sat;
			idx_q      <= '0;
			hit_q      <= !prefix_valid_q;
			hit_code_q <= CODE_W'(sym_sat);
		end else if (st_q == ST_SEARCH) begin
			if (match) begin
				hit_q      <= 1'b1;
				hit_code_q <= CODE_W'(ALPHABET_SIZE) + CODE_W'(idx_q);
			end else if (!last) begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/lzw_compressor_core.sv -----
// Streaming LZW compressor with a final packed output form.
// Input channel: in_valid, in_stall and symbol. A request is taken when
// in_valid is high and in_stall is low; symbols at or above the alphabet size
// are treated as the last symbol of the alphabet.
// Output channel: out_valid, out_stall and the fields has_code, code,
// is_final and final_symbol. Every input request produces exactly one output
// request, held stable while out_stall is high.
// Configuration: final_code_count is written when cfg_valid and cfg_ready are
// both high; cfg_ready is always high and writes belong in idle periods.
// Each symbol scans the learned table in a memory with one read and one write
// port, one entry per cycle; a hit ends the scan at that entry, and no scan
// runs while no prefix is held or the table is empty. The output register
// lets the next symbol be taken while a result waits; if it is still full
// when a search finishes, the engine holds in its final step and in_stall
// stays high.
// Reset clears the prefix, the table fill count and the emitted count; the
// table contents need no clearing since only filled entries are read.
module lzw_compressor_core #(
	parameter int ALPHABET_SIZE = 1000,
	parameter int DICT_ENTRIES  = 1023
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lzwc_pkg::COUNT_W-1:0]   final_code_count,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [lzwc_pkg::SYM_W-1:0]     symbol,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           has_code,
	output logic [lzwc_pkg::CODE_W-1:0]    code,
	output logic                           is_final,
	output logic [lzwc_pkg::SYM_W-1:0]     final_symbol
);
	import lzwc_pkg::*;

	logic [COUNT_W-1:0] final_count_q;
	logic               out_valid_q;
	result_t            out_q;
	logic               out_free;
	logic               res_valid;
	result_t            res;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			final_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			final_count_q <= final_code_count;
		end
	end

	lzwc_engine #(
		.ALPHABET_SIZE (ALPHABET_SIZE),
		.DICT_ENTRIES  (DICT_ENTRIES)
	) u_engine (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.symbol           (symbol),
		.final_code_count (final_count_q),
		.out_free         (out_free),
		.res_valid        (res_valid),
		.res              (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign has_code     = out_q.has_code;
	assign code         = out_q.code;
	assign is_final     = out_q.is_final;
	assign final_symbol = out_q.final_symbol;

endmodule
